/* sv/tlps_pkg.sv */
`timescale 1ns / 1ps
// tlps_pkg: shared widths, register and operation codes, command/status structs
// for the tile layer parallax scanner; no dependencies

package tlps_pkg;

    // field widths
    localparam int CAM_W      = 16;
    localparam int ROFF_W     = 6;
    localparam int PCT_W      = 9;
    localparam int TSZ_W      = 9;
    localparam int MSZ_W      = 13;
    localparam int WRAP_W     = 2;
    localparam int IDX_W      = 24;
    localparam int SCR_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // internal widths
    localparam int PROD_W  = CAM_W + PCT_W;   // camera times percent
    localparam int PCX_W   = 19;              // max product / 100 fits here
    localparam int COL_W   = PCX_W + 1;       // start column plus up to 63
    localparam int RB_W    = 2 * MSZ_W;       // row times map columns
    localparam int DIV_NW  = PROD_W;
    localparam int DIV_DW  = MSZ_W;
    localparam int NCOL_W  = 7;

    // divide by 100 as (p * PCT_RCP) >> RCP_SHIFT, exact for p below 2^30
    localparam int RCP_W     = 26;
    localparam int RCP_SHIFT = 32;
    localparam int SCALE_W   = PROD_W + RCP_W;
    localparam logic [RCP_W-1:0] PCT_RCP = 26'd42949673;

    localparam int MAX_COLS  = 64;
    localparam int PERCENT   = 100;
    localparam int PAD_TOTAL = 200;

    localparam int VIEW_WIDTH_DEF  = 640;
    localparam int VIEW_HEIGHT_DEF = 480;

    // register reset values
    localparam logic [TSZ_W-1:0]  TW_RST   = TSZ_W'(64);
    localparam logic [TSZ_W-1:0]  TH_RST   = TSZ_W'(64);
    localparam logic [MSZ_W-1:0]  MC_RST   = MSZ_W'(64);
    localparam logic [MSZ_W-1:0]  MR_RST   = MSZ_W'(64);
    localparam logic [PCT_W-1:0]  PX_RST   = PCT_W'(100);
    localparam logic [PCT_W-1:0]  PY_RST   = PCT_W'(100);
    localparam logic [WRAP_W-1:0] WRAP_RST = WRAP_W'(0);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLAX_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLAX_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd6;

    // divider operations, issued in this order
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_COLX = 4'd2;  // pcx / tile_width
    localparam logic [OP_W-1:0] OP_ROWY = 4'd3;  // pcy / tile_height
    localparam logic [OP_W-1:0] OP_VW   = 4'd4;  // view width / tile_width
    localparam logic [OP_W-1:0] OP_PW   = 4'd5;  // pad / tile_width
    localparam logic [OP_W-1:0] OP_VH   = 4'd6;  // view height / tile_height
    localparam logic [OP_W-1:0] OP_PH   = 4'd7;  // pad / tile_height
    localparam logic [OP_W-1:0] OP_RMOD = 4'd8;  // row mod map_rows
    localparam logic [OP_W-1:0] OP_CMOD = 4'd9;  // start column mod map_columns

    typedef struct packed {
        logic            load_in;
        logic            scale;
        logic            div_start;
        logic [OP_W-1:0] op;
        logic            div_capture;
        logic            setup_row;
        logic            emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic skip;
        logic last_col;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/tlps_if.sv */
`timescale 1ns / 1ps
// tlps_if: valid/ready channel interfaces for input words, result words and
// register writes; depends on tlps_pkg

interface tlps_in_if import tlps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CAM_W-1:0]  camera_x;
    logic [CAM_W-1:0]  camera_y;
    logic [ROFF_W-1:0] row_offset;

    modport source (output valid, output camera_x, output camera_y, output row_offset,
                    input ready);
    modport sink (input valid, input camera_x, input camera_y, input row_offset,
                  output ready);
endinterface

interface tlps_out_if import tlps_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        tile_index;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    in_bounds;
    logic                    last;

    modport source (output valid, output tile_index, output screen_x, output screen_y,
                    output in_bounds, output last, input ready);
    modport sink (input valid, input tile_index, input screen_x, input screen_y,
                  input in_bounds, input last, output ready);
endinterface

interface tlps_cfg_if import tlps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

/* sv/tlps_div.sv */
`timescale 1ns / 1ps
// tlps_div: restoring divider, one quotient bit per cycle, quotient and remainder
// held after done; depends on tlps_pkg

module tlps_div import tlps_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          fits;

    assign shifted = {r_rem, r_quo[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = ~diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

/* sv/tlps_ctrl.sv */
`timescale 1ns / 1ps
// tlps_ctrl: sequencer for the scanner, walks the scaling, the divider operations,
// the row setup and the column emission; depends on tlps_pkg

module tlps_ctrl import tlps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = OP_COLX;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    if (r_op == OP_PH) begin
                        n_state = S_CHECK;
                    end else if (r_op == OP_CMOD) begin
                        n_state = S_MUL;
                    end else begin
                        n_op    = r_op + OP_W'(1);
                        n_state = S_DIV;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else begin
                    n_op    = OP_RMOD;
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                o_cmd.setup_row = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_col) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_COLX;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SCALE && r_op == OP_COLX))
        else $error("accepted word did not start the setup sequence");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last_col) |=> r_state == S_IDLE)
        else $error("row did not end after its last column");

    a_div_multicycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider finished in one cycle");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == S_WAIT)
        else $error("divider done outside of wait state");

endmodule

/* sv/tlps_dp.sv */
`timescale 1ns / 1ps
// tlps_dp: registers, percent scaling, operand select, shared divider, row setup
// and column stepping with the output register; depends on tlps_pkg, tlps_if, tlps_div

module tlps_dp import tlps_pkg::*; #(
    parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [CAM_W-1:0]      i_camera_x,
    input  logic [CAM_W-1:0]      i_camera_y,
    input  logic [ROFF_W-1:0]     i_row_offset,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlps_out_if.source            o_out
);
    localparam int NX_W = $clog2(VIEW_WIDTH + PAD_TOTAL + 1);
    localparam int NY_W = $clog2(VIEW_HEIGHT + PAD_TOTAL + 1);

    // registers
    logic [TSZ_W-1:0]  r_tw, r_th;
    logic [MSZ_W-1:0]  r_mc, r_mr;
    logic [PCT_W-1:0]  r_px, r_py;
    logic [WRAP_W-1:0] r_wrap;

    // zero size reads as one
    logic [TSZ_W-1:0] tw, th;
    logic [MSZ_W-1:0] mc, mr;
    assign tw = (r_tw == '0) ? TSZ_W'(1) : r_tw;
    assign th = (r_th == '0) ? TSZ_W'(1) : r_th;
    assign mc = (r_mc == '0) ? MSZ_W'(1) : r_mc;
    assign mr = (r_mr == '0) ? MSZ_W'(1) : r_mr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw   <= TW_RST;
            r_th   <= TH_RST;
            r_mc   <= MC_RST;
            r_mr   <= MR_RST;
            r_px   <= PX_RST;
            r_py   <= PY_RST;
            r_wrap <= WRAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_idx)
                REG_TILE_WIDTH:  r_tw   <= i_cfg_data[TSZ_W-1:0];
                REG_TILE_HEIGHT: r_th   <= i_cfg_data[TSZ_W-1:0];
                REG_MAP_COLUMNS: r_mc   <= i_cfg_data[MSZ_W-1:0];
                REG_MAP_ROWS:    r_mr   <= i_cfg_data[MSZ_W-1:0];
                REG_PARALLAX_X:  r_px   <= i_cfg_data[PCT_W-1:0];
                REG_PARALLAX_Y:  r_py   <= i_cfg_data[PCT_W-1:0];
                REG_WRAP_MODE:   r_wrap <= i_cfg_data[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    // per-word working registers
    logic [PROD_W-1:0]  r_prod_x, r_prod_y;
    logic [ROFF_W-1:0]  r_roff;
    logic [PCX_W-1:0]   r_pcx, r_pcy, r_scol, r_srow;
    logic [TSZ_W-1:0]   r_remx, r_remy;
    logic [NX_W-1:0]    r_nx;
    logic [NY_W-1:0]    r_ny;
    logic [MSZ_W-1:0]   r_rmod, r_cmod;

    // column stepping
    logic [IDX_W-1:0]  r_rbase;
    logic [SCR_W-1:0]  r_sx, r_sy;
    logic [COL_W-1:0]  r_col;
    logic [MSZ_W-1:0]  r_colmod;
    logic [NCOL_W-1:0] r_k, r_ncols;
    logic              r_row_ok;

    // output register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic [SCR_W-1:0]  r_o_sx, r_o_sy;
    logic              r_o_inb, r_o_last;

    logic [COL_W-1:0]   row;
    logic [NCOL_W-1:0]  ncols_sat;
    logic               col_ok, tile_ok, last_col;
    logic [SCALE_W-1:0] scale_x, scale_y;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_DW-1:0]  div_d;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;
    logic [DIV_DW-1:0]  div_rem;

    assign row       = COL_W'(r_srow) + COL_W'(r_roff);
    assign ncols_sat = (r_nx > NX_W'(MAX_COLS)) ? NCOL_W'(MAX_COLS) : NCOL_W'(r_nx);
    assign col_ok    = r_wrap[0] || (r_col < COL_W'(mc));
    assign tile_ok   = r_row_ok && col_ok;
    assign last_col  = (r_k + NCOL_W'(1)) == r_ncols;

    // divide by 100 through the reciprocal, quotient in the top bits
    assign scale_x = SCALE_W'(r_prod_x) * SCALE_W'(PCT_RCP);
    assign scale_y = SCALE_W'(r_prod_y) * SCALE_W'(PCT_RCP);

    // divider operand select
    always_comb begin
        case (i_cmd.op)
            OP_COLX: begin
                div_n = DIV_NW'(r_pcx);
                div_d = DIV_DW'(tw);
            end
            OP_ROWY: begin
                div_n = DIV_NW'(r_pcy);
                div_d = DIV_DW'(th);
            end
            OP_VW: begin
                div_n = DIV_NW'(VIEW_WIDTH);
                div_d = DIV_DW'(tw);
            end
            OP_PW: begin
                div_n = DIV_NW'(PAD_TOTAL);
                div_d = DIV_DW'(tw);
            end
            OP_VH: begin
                div_n = DIV_NW'(VIEW_HEIGHT);
                div_d = DIV_DW'(th);
            end
            OP_PH: begin
                div_n = DIV_NW'(PAD_TOTAL);
                div_d = DIV_DW'(th);
            end
            OP_RMOD: begin
                div_n = DIV_NW'(row);
                div_d = mr;
            end
            OP_CMOD: begin
                div_n = DIV_NW'(r_scol);
                div_d = mc;
            end
            default: begin
                div_n = '0;
                div_d = DIV_DW'(1);
            end
        endcase
    end

    tlps_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_prod_x <= PROD_W'(i_camera_x) * PROD_W'(r_px);
            r_prod_y <= PROD_W'(i_camera_y) * PROD_W'(r_py);
            r_roff   <= i_row_offset;
        end
        if (i_cmd.scale) begin
            r_pcx <= scale_x[RCP_SHIFT +: PCX_W];
            r_pcy <= scale_y[RCP_SHIFT +: PCX_W];
        end
        if (i_cmd.div_capture) begin
            case (i_cmd.op)
                OP_COLX: begin
                    r_scol <= div_quo[PCX_W-1:0];
                    r_remx <= div_rem[TSZ_W-1:0];
                end
                OP_ROWY: begin
                    r_srow <= div_quo[PCX_W-1:0];
                    r_remy <= div_rem[TSZ_W-1:0];
                end
                OP_VW:   r_nx <= div_quo[NX_W-1:0];
                OP_PW:   r_nx <= r_nx + div_quo[NX_W-1:0];
                OP_VH:   r_ny <= div_quo[NY_W-1:0];
                OP_PH:   r_ny <= r_ny + div_quo[NY_W-1:0];
                OP_RMOD: r_rmod <= div_rem;
                OP_CMOD: r_cmod <= div_rem;
                default: ;
            endcase
        end
        if (i_cmd.setup_row) begin
            r_rbase  <= IDX_W'(RB_W'(r_rmod) * RB_W'(mc));
            r_sy     <= SCR_W'(SCR_W'(r_roff) * SCR_W'(th)) - SCR_W'(r_remy);
            r_sx     <= SCR_W'(0) - SCR_W'(r_remx);
            r_col    <= COL_W'(r_scol);
            r_colmod <= r_cmod;
            r_k      <= '0;
            r_ncols  <= ncols_sat;
            r_row_ok <= r_wrap[1] || (row < COL_W'(mr));
        end else if (i_cmd.emit) begin
            r_o_idx  <= tile_ok ? (r_rbase + IDX_W'(r_colmod)) : '0;
            r_o_sx   <= r_sx;
            r_o_sy   <= r_sy;
            r_o_inb  <= tile_ok;
            r_o_last <= last_col;
            r_k      <= r_k + NCOL_W'(1);
            r_col    <= r_col + COL_W'(1);
            r_colmod <= (r_colmod == mc - MSZ_W'(1)) ? '0 : r_colmod + MSZ_W'(1);
            r_sx     <= r_sx + SCR_W'(tw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tile_index = r_o_idx;
    assign o_out.screen_x   = r_o_sx;
    assign o_out.screen_y   = r_o_sy;
    assign o_out.in_bounds  = r_o_inb;
    assign o_out.last       = r_o_last;

    assign o_sts.div_done = div_done;
    assign o_sts.skip     = (NY_W'(r_roff) >= r_ny) || (ncols_sat == '0);
    assign o_sts.last_col = last_col;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    a_colmod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_colmod < mc)
        else $error("wrapped column index out of range");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_k < r_ncols)
        else $error("column emitted beyond the row count");

    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_k == '0) |-> r_col == COL_W'(r_scol))
        else $error("first column does not match start column");

endmodule

/* sv/tile_layer_parallax_scan.sv */
`timescale 1ns / 1ps
// throughput: after the setup, a row of n columns (up to 64) comes out at one word a cycle
// while the output is not held back; the next row request is taken once the last column is emitted
// a row with no visible columns returns to idle after its setup divides, with no row setup
// the shared one-bit-a-cycle divider sets the setup time: eight divides in series for a visible row
// reset: synchronous active low, registers to their defaults, no word pending
// top level: depends on tlps_pkg, tlps_if, tlps_ctrl, tlps_dp (with tlps_div)

module tile_layer_parallax_scan import tlps_pkg::*; #(
    parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlps_in_if.sink     i_in,
    tlps_out_if.source  o_out,
    tlps_cfg_if.sink    i_cfg
);
    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // register writes are always taken; the host must write only while idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    // sequencer: accepts a word only when idle, then runs the scaling, the divides and,
    // for a row with visible columns, the row setup and one column per free output slot
    tlps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: register file, scaling, divider, column stepping and the
    // output register that lets the next word be taken while a result waits
    tlps_dp #(
        .VIEW_WIDTH  (VIEW_WIDTH),
        .VIEW_HEIGHT (VIEW_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_camera_x   (i_in.camera_x),
        .i_camera_y   (i_in.camera_y),
        .i_row_offset (i_in.row_offset),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_idx    (i_cfg.idx),
        .i_cfg_data   (i_cfg.data),
        .o_out        (o_out)
    );

endmodule

/* dv/tlps_scan_checker.sv */
`timescale 1ns / 1ps
// tlps_scan_checker: watches the row request, tile word and register channels of the
// tile layer scanner, predicts every tile word of a row and compares it in order
// depends on tlps_pkg and tlps_if

module tlps_scan_checker import tlps_pkg::*; #(
    parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tlps_in_if   i_in,
    tlps_out_if  i_out,
    tlps_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_outstanding,
    output int   o_words_checked
);

    typedef struct packed {
        logic [IDX_W-1:0]        tile_index;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic                    in_bounds;
        logic                    last;
    } t_tile_word;

    logic [TSZ_W-1:0]  tile_w;
    logic [TSZ_W-1:0]  tile_h;
    logic [MSZ_W-1:0]  map_cols;
    logic [MSZ_W-1:0]  map_rows;
    logic [PCT_W-1:0]  pct_x;
    logic [PCT_W-1:0]  pct_y;
    logic [WRAP_W-1:0] wrap;

    t_tile_word tiles_due[$];
    int         errors;
    int         words_checked;

    // a size register at zero behaves as one
    function automatic int unsigned nonzero(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // queue up every tile word that one row request should produce
    function automatic void scan_row(logic [CAM_W-1:0] cam_x, logic [CAM_W-1:0] cam_y,
                                     logic [ROFF_W-1:0] roff);
        int unsigned tw, th, mc, mr, pcx, pcy, first_col, row, ncols, nrows;
        int unsigned col, sx, sy, idx, k;
        logic        row_ok, ok;
        t_tile_word  w;
        tw = nonzero(tile_w);
        th = nonzero(tile_h);
        mc = nonzero(map_cols);
        mr = nonzero(map_rows);
        pcx = (32'(cam_x) * 32'(pct_x)) / 32'(PERCENT);
        pcy = (32'(cam_y) * 32'(pct_y)) / 32'(PERCENT);
        first_col = pcx / tw;
        ncols = 32'(VIEW_WIDTH) / tw + 32'(PAD_TOTAL) / tw;
        nrows = 32'(VIEW_HEIGHT) / th + 32'(PAD_TOTAL) / th;
        if (ncols > MAX_COLS)
            ncols = MAX_COLS;
        if (32'(roff) >= nrows || ncols == 0)
            return;
        row = pcy / th + 32'(roff);
        row_ok = wrap[1] || (row < mr);
        sy = 32'(roff) * th - (pcy % th);
        for (k = 0; k < ncols; k++) begin
            col = first_col + k;
            ok = row_ok && (wrap[0] || (col < mc));
            sx = k * tw - (pcx % tw);
            idx = (row % mr) * mc + (col % mc);
            w.tile_index = ok ? idx[IDX_W-1:0] : '0;
            w.screen_x = sx[SCR_W-1:0];
            w.screen_y = sy[SCR_W-1:0];
            w.in_bounds = ok;
            w.last = (k + 1 == ncols);
            tiles_due.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_tile_word got;
        t_tile_word want;
        if (!i_rst_n) begin
            tile_w   <= TW_RST;
            tile_h   <= TH_RST;
            map_cols <= MC_RST;
            map_rows <= MR_RST;
            pct_x    <= PX_RST;
            pct_y    <= PY_RST;
            wrap     <= WRAP_RST;
            tiles_due.delete();
            errors = 0;
            words_checked = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.tile_index, i_out.screen_x, i_out.screen_y,
                        i_out.in_bounds, i_out.last};
                words_checked++;
                if (tiles_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected tile word idx %0d sx %0d sy %0d in %0b last %0b",
                             $time, got.tile_index, got.screen_x, got.screen_y,
                             got.in_bounds, got.last);
                end else begin
                    want = tiles_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: tile word mismatch", $time);
                        $display("  expected idx %0d sx %0d sy %0d in %0b last %0b",
                                 want.tile_index, want.screen_x, want.screen_y,
                                 want.in_bounds, want.last);
                        $display("  actual   idx %0d sx %0d sy %0d in %0b last %0b",
                                 got.tile_index, got.screen_x, got.screen_y,
                                 got.in_bounds, got.last);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    REG_TILE_WIDTH:  tile_w   <= i_cfg.data[TSZ_W-1:0];
                    REG_TILE_HEIGHT: tile_h   <= i_cfg.data[TSZ_W-1:0];
                    REG_MAP_COLUMNS: map_cols <= i_cfg.data[MSZ_W-1:0];
                    REG_MAP_ROWS:    map_rows <= i_cfg.data[MSZ_W-1:0];
                    REG_PARALLAX_X:  pct_x    <= i_cfg.data[PCT_W-1:0];
                    REG_PARALLAX_Y:  pct_y    <= i_cfg.data[PCT_W-1:0];
                    REG_WRAP_MODE:   wrap     <= i_cfg.data[WRAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                scan_row(i_in.camera_x, i_in.camera_y, i_in.row_offset);
        end
        o_outstanding   <= tiles_due.size();
        o_errors        <= errors;
        o_words_checked <= words_checked;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: top for the tile layer parallax scanner; makes row requests, register
// writes and result back-pressure, and reports the verdict
// depends on tlps_pkg, tlps_if, tlps_scan_checker and tile_layer_parallax_scan

module testbench;
    import tlps_pkg::*;

    localparam int VIEW_W           = VIEW_WIDTH_DEF;
    localparam int VIEW_H           = VIEW_HEIGHT_DEF;
    localparam int MAX_WAIT         = 17;
    // a row with no visible columns still keeps the block busy through its setup divides
    localparam int SETTLE_CYCLES    = 600;
    localparam int IDLE_LIMIT       = 5000;
    localparam int FIXED_SETTINGS   = 5;
    localparam int RANDOM_SETTINGS  = 4;
    localparam int ROWS_PER_SETTING = 16;
    // no register lives here, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic i_clk;
    logic i_rst_n;

    tlps_in_if  in_ch();
    tlps_out_if out_ch();
    tlps_cfg_if cfg_ch();

    int   errors;
    int   outstanding;
    int   words_checked;
    int   idle_cycles;
    int   rows_sent;
    int   settings_run;
    logic quiet;

    // register values as last written, used to aim requests at map edges
    int unsigned cur_tw, cur_th, cur_mc, cur_mr, cur_px, cur_py;

    tile_layer_parallax_scan #(
        .VIEW_WIDTH  (VIEW_W),
        .VIEW_HEIGHT (VIEW_H)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tlps_scan_checker #(
        .VIEW_WIDTH  (VIEW_W),
        .VIEW_HEIGHT (VIEW_H)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .i_cfg           (cfg_ch),
        .o_errors        (errors),
        .o_outstanding   (outstanding),
        .o_words_checked (words_checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // visible rows for the current tile height
    function automatic int unsigned visible_rows();
        int unsigned th;
        th = (cur_th == 0) ? 1 : cur_th;
        return 32'(VIEW_H) / th + 32'(PAD_TOTAL) / th;
    endfunction

    // camera position whose scaled value lands a little around a map edge
    function automatic int unsigned near_edge(longint unsigned span, int unsigned pct);
        longint unsigned cam;
        int unsigned     back;
        if (pct == 0)
            return $urandom_range(0, 65535);
        cam = span * PERCENT / pct + $urandom_range(0, 200);
        back = $urandom_range(0, 1600);
        cam = (cam > back) ? cam - back : 0;
        if (cam > 65535)
            cam = 65535 - $urandom_range(0, 1023);
        return 32'(cam);
    endfunction

    // one row request word; valid stays up when the next word follows at once
    task automatic send_row(input int unsigned cx, input int unsigned cy,
                            input int unsigned roff);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.camera_x   <= CAM_W'(cx);
        in_ch.camera_y   <= CAM_W'(cy);
        in_ch.row_offset <= ROFF_W'(roff);
        do @(posedge i_clk); while (!in_ch.ready);
        rows_sent++;
    endtask

    task automatic random_row();
        int unsigned cx, cy, roff, nrows, pick, tw, th, mc, mr;
        tw = (cur_tw == 0) ? 1 : cur_tw;
        th = (cur_th == 0) ? 1 : cur_th;
        mc = (cur_mc == 0) ? 1 : cur_mc;
        mr = (cur_mr == 0) ? 1 : cur_mr;
        nrows = visible_rows();
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
        end else if (pick == 1) begin
            cx = $urandom_range(0, 2047);
            cy = $urandom_range(0, 2047);
        end else begin
            cx = near_edge(longint'(mc) * tw, cur_px);
            cy = near_edge(longint'(mr) * th, cur_py);
        end
        // mostly rows that are on screen, some beyond the last visible row
        if (nrows != 0 && $urandom_range(0, 4) != 0)
            roff = $urandom_range(0, (nrows > 64) ? 63 : nrows - 1);
        else
            roff = $urandom_range(0, 63);
        send_row(cx, cy, roff);
    endtask

    // holds valid high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_TILE_WIDTH:  cur_tw = data[TSZ_W-1:0];
            REG_TILE_HEIGHT: cur_th = data[TSZ_W-1:0];
            REG_MAP_COLUMNS: cur_mc = data[MSZ_W-1:0];
            REG_MAP_ROWS:    cur_mr = data[MSZ_W-1:0];
            REG_PARALLAX_X:  cur_px = data[PCT_W-1:0];
            REG_PARALLAX_Y:  cur_py = data[PCT_W-1:0];
            default: ;
        endcase
    endtask

    // full register set; noisy puts junk above each register's width
    task automatic apply_setting(input int unsigned tw, input int unsigned th,
                                 input int unsigned mc, input int unsigned mr,
                                 input int unsigned px, input int unsigned py,
                                 input int unsigned wrap, input bit noisy);
        logic [CFG_DATA_W-1:0] junk;
        junk = noisy ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_TILE_WIDTH, CFG_DATA_W'(tw) | (junk << TSZ_W));
        write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(th) | (junk << TSZ_W));
        write_reg(REG_MAP_COLUMNS, CFG_DATA_W'(mc));
        write_reg(REG_MAP_ROWS, CFG_DATA_W'(mr));
        write_reg(REG_PARALLAX_X, CFG_DATA_W'(px) | (junk << PCT_W));
        write_reg(REG_PARALLAX_Y, CFG_DATA_W'(py) | (junk << PCT_W));
        write_reg(REG_WRAP_MODE, CFG_DATA_W'(wrap) | (junk << WRAP_W));
        cfg_ch.valid <= 1'b0;
        settings_run++;
    endtask

    // wait for every expected tile word, then let a wordless row finish too
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // size picks for random settings: mostly a usual range, now and then anything
    function automatic int unsigned pick_size(int unsigned lo, int unsigned hi,
                                              int unsigned full);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, full) : $urandom_range(lo, hi);
    endfunction

    // main stimulus
    initial begin : stimulus
        int          k;
        int unsigned last_row;
        in_ch.valid      <= 1'b0;
        in_ch.camera_x   <= '0;
        in_ch.camera_y   <= '0;
        in_ch.row_offset <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.idx       <= '0;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        quiet        = 1'b0;
        rows_sent    = 0;
        settings_run = 1;
        cur_tw = TW_RST;
        cur_th = TH_RST;
        cur_mc = MC_RST;
        cur_mr = MR_RST;
        cur_px = PX_RST;
        cur_py = PY_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: 64 px tiles on a 64x64 map, 13 columns, 10 rows visible
        send_row(0, 0, 0);
        send_row(65535, 65535, 0);    // whole row off the map
        send_row(3328, 0, 0);         // last column sits exactly at the map width
        send_row(3300, 0, 0);         // partial tile on the left edge
        send_row(0, 4032, 0);         // final map row, still inside
        send_row(0, 4032, 1);         // one row past the map
        send_row(0, 0, 9);            // last visible row
        send_row(0, 0, 10);           // first row past the window, no words
        send_row(0, 0, 63);
        send_row(65535, 0, 5);
        send_row(1, 1, 1);
        send_row(32768, 21845, 42);
        drain();

        for (k = 0; k < FIXED_SETTINGS + RANDOM_SETTINGS; k++) begin
            case (k)
                0: apply_setting(16, 16, 1, 1, 0, 0, 0, 1'b0);
                1: apply_setting(256, 256, 4096, 4096, 400, 400, 3, 1'b0);
                2: apply_setting(0, 0, 0, 0, 511, 511, 1, 1'b0);  // zero sizes act as one
                3: apply_setting(511, 300, 8191, 8191, 1, 1, 2, 1'b0);
                4: apply_setting(100, 511, 5, 3, 200, 50, 3, 1'b0); // no visible rows
                default: apply_setting(pick_size(16, 256, 511), pick_size(16, 256, 511),
                                       pick_size(1, 96, 8191), pick_size(1, 96, 8191),
                                       $urandom_range(0, 511), $urandom_range(0, 511),
                                       $urandom_range(0, 3), 1'b1);
            endcase
            // some settings run with no gaps at all on either side
            quiet = ($urandom_range(0, 3) == 0);
            if (k < FIXED_SETTINGS) begin
                last_row = visible_rows();
                last_row = (last_row == 0) ? 0 : ((last_row > 64) ? 63 : last_row - 1);
                send_row(0, 0, 0);
                send_row(65535, 65535, last_row);
            end
            repeat ((k == 4) ? 2 : ROWS_PER_SETTING) random_row();
            drain();
        end

        $display("covered %0d row requests under %0d register settings", rows_sent,
                 settings_run);
        $display("%0d tile words compared, %0d mismatches", words_checked, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side: a fresh stall before every tile word
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // watchdog on cycles where no word moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d tile words still due",
                     $time, idle_cycles, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
